// ===== src/mlpsig_pkg.sv =====
// ----------------------------------------------------------------------------
// mlpsig_pkg
// Shared types, constants and fixed-point helpers for the sigmoid perceptron.
// ----------------------------------------------------------------------------
package mlpsig_pkg;

	// Network shape
	localparam int IN_COUNT     = 2;
	localparam int HIDDEN_COUNT = 4;
	localparam int OUT_COUNT    = 3;

	// Store layout
	localparam int OFF_HO      = IN_COUNT * HIDDEN_COUNT;
	localparam int OFF_BH      = OFF_HO + HIDDEN_COUNT * OUT_COUNT;
	localparam int OFF_BO      = OFF_BH + HIDDEN_COUNT;
	localparam int STORE_DEPTH = OFF_BO + OUT_COUNT;
	localparam int STORE_AW    = $clog2(STORE_DEPTH);

	localparam int HID_W = (HIDDEN_COUNT > 1) ? $clog2(HIDDEN_COUNT) : 1;
	localparam int OUT_W = 2;

	// Sigmoid table (power-of-two depth)
	localparam int SIG_DEPTH = 256;
	localparam int SIG_ABITS = $clog2(SIG_DEPTH);

	// Item modes
	localparam logic [1:0] MODE_PREDICT = 2'd0;
	localparam logic [1:0] MODE_TRAIN   = 2'd1;
	localparam logic [1:0] MODE_LOAD    = 2'd2;
	localparam logic [1:0] MODE_SPARE   = 2'd3;  // no operation, zero result

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [15:0] x_first;
		logic signed [15:0] x_second;
		logic [12:0]        target_first;
		logic [12:0]        target_second;
		logic [12:0]        target_third;
		logic [4:0]         weight_index;
		logic signed [15:0] weight_value;
	} req_t;

	typedef struct packed {
		logic [12:0] y_first;
		logic [12:0] y_second;
		logic [12:0] y_third;
	} rsp_t;

	// Datapath micro-operations
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,  // write one store word
		OP_HB,    // acc = hidden bias
		OP_HX,    // acc += x * w_ih
		OP_HS,    // h = sigmoid(acc)
		OP_OB,    // acc = output bias
		OP_OH,    // acc += h * w_ho
		OP_OS,    // y = sigmoid(acc)
		OP_DY,    // tmp = y derivative
		OP_DO,    // output delta
		OP_HC,    // acc = 0
		OP_HE,    // acc += dout * w_ho
		OP_DH1,   // tmp = h derivative, tmp2 = back-propagated error
		OP_DH2,   // hidden delta
		OP_UIH,   // update input-hidden weight
		OP_UHO,   // update hidden-output weight
		OP_UBH,   // update hidden bias
		OP_UBO    // update output bias
	} op_t;

	typedef struct packed {
		op_t              op;
		logic             capture;
		logic             finish;
		logic             sel_i;
		logic [HID_W-1:0] sel_j;
		logic [OUT_W-1:0] sel_k;
	} cmd_t;

	typedef logic [12:0] sig_tab_t [SIG_DEPTH];

	// Shift-subtract divide, elaboration use only
	function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		logic [63:0] r;
		q = '0;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			r = {r[62:0], n[b]};
			if (r >= d) begin
				r    = r - d;
				q[b] = 1'b1;
			end
		end
		return q;
	endfunction

	// exp(-u/4096) in Q30: series at u/8, squared three times
	function automatic logic [63:0] exp_neg_q30(input logic [63:0] u);
		logic signed [63:0] term;
		logic signed [63:0] sum;
		logic [63:0]        sq;
		term = 64'sd1 <<< 30;
		sum  = 64'sd1 <<< 30;
		for (int k = 1; k <= 14; k++) begin
			term = $signed(udiv64(64'(term) * u, 64'(32768 * k)));
			if (k[0])
				sum = sum - term;
			else
				sum = sum + term;
		end
		if (sum < 0)
			sum = '0;
		sq = 64'(sum);
		for (int n = 0; n < 3; n++)
			sq = (sq * sq + (64'd1 << 29)) >> 30;
		return sq;
	endfunction

	function automatic sig_tab_t build_sig_table();
		sig_tab_t           t;
		logic signed [63:0] c;
		logic [63:0]        m;
		logic [63:0]        ex;
		logic [63:0]        den;
		logic [63:0]        val;
		for (int e = 0; e < SIG_DEPTH; e++) begin
			c   = 64'(((2 * e + 1) * 32768) / SIG_DEPTH) - 64'sd32768;
			m   = (c < 0) ? 64'(-c) : 64'(c);
			ex  = exp_neg_q30(m);
			den = (64'd1 << 30) + ex;
			if (c >= 0)
				val = udiv64((64'd1 << 43) + den, den << 1);
			else
				val = udiv64(ex * 64'd8192 + den, den << 1);
			t[e] = val[12:0];
		end
		return t;
	endfunction

	localparam sig_tab_t SIG_TABLE = build_sig_table();

	// Round half up from Q.24 (or wider) to Q4.12 and saturate
	function automatic logic signed [15:0] rnd_sat(input logic signed [39:0] p);
		logic signed [39:0] s;
		logic signed [27:0] q;
		s = p + 40'sd2048;
		q = s[39:12];
		if (q > 28'sd32767)
			return 16'sh7fff;
		else if (q < -28'sd32768)
			return 16'sh8000;
		else
			return q[15:0];
	endfunction

	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [16:0] s;
		s = {a[15], a} + {b[15], b};
		if (s > 17'sd32767)
			return 16'sh7fff;
		else if (s < -17'sd32768)
			return 16'sh8000;
		else
			return s[15:0];
	endfunction

	function automatic logic [12:0] sigmoid(input logic signed [15:0] v);
		logic [15:0] u;
		u = {~v[15], v[14:0]};
		return SIG_TABLE[u[15 -: SIG_ABITS]];
	endfunction

endpackage

// ===== src/mlpsig_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlpsig_ctrl
// Sequencer: steps the datapath through forward, delta and update passes.
// ----------------------------------------------------------------------------
module mlpsig_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  logic [1:0]         mode,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output mlpsig_pkg::cmd_t   cmd
);

	typedef enum logic [1:0] {S_IDLE, S_WORK, S_OUT} state_t;

	localparam logic [mlpsig_pkg::HID_W-1:0] J_LAST =
		mlpsig_pkg::HID_W'(mlpsig_pkg::HIDDEN_COUNT - 1);
	localparam logic [mlpsig_pkg::OUT_W-1:0] K_LAST =
		mlpsig_pkg::OUT_W'(mlpsig_pkg::OUT_COUNT - 1);

	state_t                         state_q;
	mlpsig_pkg::op_t                op_q;
	logic                           i_q;
	logic [mlpsig_pkg::HID_W-1:0]   j_q;
	logic [mlpsig_pkg::OUT_W-1:0]   k_q;
	logic                           train_q;
	logic                           rsp_valid_q;
	logic                           out_free;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign out_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd.op      = (state_q == S_WORK) ? op_q : mlpsig_pkg::OP_NONE;
		cmd.capture = req_valid && req_ready;
		cmd.finish  = (state_q == S_OUT) && out_free;
		cmd.sel_i   = i_q;
		cmd.sel_j   = j_q;
		cmd.sel_k   = k_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= mlpsig_pkg::OP_NONE;
			i_q         <= 1'b0;
			j_q         <= '0;
			k_q         <= '0;
			train_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			// a new result replaces the one being taken in the same cycle
			if (state_q == S_OUT && out_free)
				rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && rsp_ready)
				rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						train_q <= (mode == mlpsig_pkg::MODE_TRAIN);
						i_q     <= 1'b0;
						j_q     <= '0;
						k_q     <= '0;
						if (mode == mlpsig_pkg::MODE_LOAD) begin
							state_q <= S_WORK;
							op_q    <= mlpsig_pkg::OP_LOAD;
						end else if (mode == mlpsig_pkg::MODE_PREDICT ||
							mode == mlpsig_pkg::MODE_TRAIN) begin
							state_q <= S_WORK;
							op_q    <= mlpsig_pkg::OP_HB;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_WORK: begin
					case (op_q)
						mlpsig_pkg::OP_LOAD: state_q <= S_OUT;
						mlpsig_pkg::OP_HB: op_q <= mlpsig_pkg::OP_HX;
						mlpsig_pkg::OP_HX: begin
							i_q <= !i_q;
							if (i_q)
								op_q <= mlpsig_pkg::OP_HS;
						end
						mlpsig_pkg::OP_HS: begin
							if (j_q == J_LAST) begin
								j_q  <= '0;
								k_q  <= '0;
								op_q <= mlpsig_pkg::OP_OB;
							end else begin
								j_q  <= j_q + 1'b1;
								op_q <= mlpsig_pkg::OP_HB;
							end
						end
						mlpsig_pkg::OP_OB: begin
							j_q  <= '0;
							op_q <= mlpsig_pkg::OP_OH;
						end
						mlpsig_pkg::OP_OH: begin
							if (j_q == J_LAST) begin
								j_q  <= '0;
								op_q <= mlpsig_pkg::OP_OS;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
						mlpsig_pkg::OP_OS: begin
							if (k_q == K_LAST) begin
								k_q <= '0;
								if (train_q) begin
									op_q <= mlpsig_pkg::OP_DY;
								end else begin
									op_q    <= mlpsig_pkg::OP_NONE;
									state_q <= S_OUT;
								end
							end else begin
								k_q  <= k_q + 1'b1;
								op_q <= mlpsig_pkg::OP_OB;
							end
						end
						mlpsig_pkg::OP_DY: op_q <= mlpsig_pkg::OP_DO;
						mlpsig_pkg::OP_DO: begin
							if (k_q == K_LAST) begin
								k_q  <= '0;
								j_q  <= '0;
								op_q <= mlpsig_pkg::OP_HC;
							end else begin
								k_q  <= k_q + 1'b1;
								op_q <= mlpsig_pkg::OP_DY;
							end
						end
						mlpsig_pkg::OP_HC: begin
							k_q  <= '0;
							op_q <= mlpsig_pkg::OP_HE;
						end
						mlpsig_pkg::OP_HE: begin
							if (k_q == K_LAST) begin
								k_q  <= '0;
								op_q <= mlpsig_pkg::OP_DH1;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
						mlpsig_pkg::OP_DH1: op_q <= mlpsig_pkg::OP_DH2;
						mlpsig_pkg::OP_DH2: begin
							if (j_q == J_LAST) begin
								j_q  <= '0;
								i_q  <= 1'b0;
								op_q <= mlpsig_pkg::OP_UIH;
							end else begin
								j_q  <= j_q + 1'b1;
								op_q <= mlpsig_pkg::OP_HC;
							end
						end
						mlpsig_pkg::OP_UIH: begin
							if (j_q == J_LAST) begin
								j_q <= '0;
								i_q <= !i_q;
								if (i_q) begin
									k_q  <= '0;
									op_q <= mlpsig_pkg::OP_UHO;
								end
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
						mlpsig_pkg::OP_UHO: begin
							if (k_q == K_LAST) begin
								k_q <= '0;
								if (j_q == J_LAST) begin
									j_q  <= '0;
									op_q <= mlpsig_pkg::OP_UBH;
								end else begin
									j_q <= j_q + 1'b1;
								end
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
						mlpsig_pkg::OP_UBH: begin
							if (j_q == J_LAST) begin
								j_q  <= '0;
								k_q  <= '0;
								op_q <= mlpsig_pkg::OP_UBO;
							end else begin
								j_q <= j_q + 1'b1;
							end
						end
						mlpsig_pkg::OP_UBO: begin
							if (k_q == K_LAST) begin
								k_q     <= '0;
								op_q    <= mlpsig_pkg::OP_NONE;
								state_q <= S_OUT;
							end else begin
								k_q <= k_q + 1'b1;
							end
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_OUT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Load transactions go straight to the store write
	a_load_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && mode == mlpsig_pkg::MODE_LOAD) |=>
		(state_q == S_WORK && op_q == mlpsig_pkg::OP_LOAD))
		else $error("load transaction not sequenced to store write");

	// A pending result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && rsp_valid_q && !rsp_ready) |=> (state_q == S_OUT))
		else $error("result overwritten before being taken");

	// Loop counters stay within the network shape
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(j_q <= J_LAST) && (k_q <= K_LAST))
		else $error("loop counter out of range");

	// Predict never enters the training passes
	a_no_train: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WORK && !train_q) |->
		(op_q != mlpsig_pkg::OP_DY && op_q != mlpsig_pkg::OP_UIH))
		else $error("training step on a predict transaction");

endmodule

// ===== src/mlpsig_dp.sv =====
// ----------------------------------------------------------------------------
// mlpsig_dp
// Datapath: weight store, one shared multiply-accumulate, sigmoid lookup.
// ----------------------------------------------------------------------------
module mlpsig_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  mlpsig_pkg::cmd_t   cmd,
	input  mlpsig_pkg::req_t   req,
	output mlpsig_pkg::rsp_t   rsp
);

	localparam int AW = mlpsig_pkg::STORE_AW;

	logic signed [15:0] store_q [mlpsig_pkg::STORE_DEPTH];

	logic [1:0]         mode_q;
	logic signed [15:0] x_q    [mlpsig_pkg::IN_COUNT];
	logic [12:0]        t_q    [mlpsig_pkg::OUT_COUNT];
	logic [4:0]         widx_q;
	logic signed [15:0] wval_q;
	logic [12:0]        h_q    [mlpsig_pkg::HIDDEN_COUNT];
	logic [12:0]        y_q    [mlpsig_pkg::OUT_COUNT];
	logic signed [15:0] dout_q [mlpsig_pkg::OUT_COUNT];
	logic signed [15:0] dhid_q [mlpsig_pkg::HIDDEN_COUNT];
	logic signed [15:0] tmp_q;
	logic signed [15:0] tmp2_q;
	logic signed [39:0] acc_q;
	mlpsig_pkg::rsp_t   rsp_q;

	logic [AW-1:0]      addr;
	logic signed [15:0] w_rd;
	logic signed [15:0] x_sel;
	logic [12:0]        h_sel;
	logic [12:0]        y_sel;
	logic signed [15:0] dout_sel;
	logic signed [15:0] dhid_sel;
	logic signed [17:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [35:0] prod;
	logic signed [39:0] prod40;
	logic signed [15:0] prod_rs;
	logic               st_we;
	logic signed [15:0] st_wdata;

	assign x_sel    = cmd.sel_i ? x_q[1] : x_q[0];
	assign h_sel    = h_q[cmd.sel_j];
	assign y_sel    = y_q[cmd.sel_k];
	assign dout_sel = dout_q[cmd.sel_k];
	assign dhid_sel = dhid_q[cmd.sel_j];

	// Store address of the current step
	always_comb begin
		case (cmd.op)
			mlpsig_pkg::OP_HB, mlpsig_pkg::OP_UBH:
				addr = AW'(mlpsig_pkg::OFF_BH) + AW'(cmd.sel_j);
			mlpsig_pkg::OP_HX, mlpsig_pkg::OP_UIH:
				addr = AW'(cmd.sel_i) * AW'(mlpsig_pkg::HIDDEN_COUNT) + AW'(cmd.sel_j);
			mlpsig_pkg::OP_OH, mlpsig_pkg::OP_HE, mlpsig_pkg::OP_UHO:
				addr = AW'(mlpsig_pkg::OFF_HO) + AW'(cmd.sel_j) * AW'(mlpsig_pkg::OUT_COUNT)
					+ AW'(cmd.sel_k);
			mlpsig_pkg::OP_OB, mlpsig_pkg::OP_UBO:
				addr = AW'(mlpsig_pkg::OFF_BO) + AW'(cmd.sel_k);
			mlpsig_pkg::OP_LOAD:
				addr = AW'(widx_q);
			default:
				addr = '0;
		endcase
	end

	assign w_rd = store_q[addr];

	// Shared multiplier operand selection
	always_comb begin
		case (cmd.op)
			mlpsig_pkg::OP_HX: begin
				mul_a = {{2{x_sel[15]}}, x_sel};
				mul_b = {{2{w_rd[15]}}, w_rd};
			end
			mlpsig_pkg::OP_OH: begin
				mul_a = {5'd0, h_sel};
				mul_b = {{2{w_rd[15]}}, w_rd};
			end
			mlpsig_pkg::OP_DY: begin
				mul_a = {5'd0, y_sel};
				mul_b = 18'd4096 - {5'd0, y_sel};
			end
			mlpsig_pkg::OP_DO: begin
				mul_a = {5'd0, t_q[cmd.sel_k]} - {5'd0, y_sel};
				mul_b = {{2{tmp_q[15]}}, tmp_q};
			end
			mlpsig_pkg::OP_HE: begin
				mul_a = {{2{dout_sel[15]}}, dout_sel};
				mul_b = {{2{w_rd[15]}}, w_rd};
			end
			mlpsig_pkg::OP_DH1: begin
				mul_a = {5'd0, h_sel};
				mul_b = 18'd4096 - {5'd0, h_sel};
			end
			mlpsig_pkg::OP_DH2: begin
				mul_a = {{2{tmp2_q[15]}}, tmp2_q};
				mul_b = {{2{tmp_q[15]}}, tmp_q};
			end
			mlpsig_pkg::OP_UIH: begin
				mul_a = {{2{x_sel[15]}}, x_sel};
				mul_b = {{2{dhid_sel[15]}}, dhid_sel};
			end
			mlpsig_pkg::OP_UHO: begin
				mul_a = {5'd0, h_sel};
				mul_b = {{2{dout_sel[15]}}, dout_sel};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign prod    = mul_a * mul_b;
	assign prod40  = {{4{prod[35]}}, prod};
	assign prod_rs = mlpsig_pkg::rnd_sat(prod40);

	// Store write-back
	always_comb begin
		st_we    = 1'b0;
		st_wdata = w_rd;
		case (cmd.op)
			mlpsig_pkg::OP_LOAD: begin
				st_we    = ({27'd0, widx_q} < 32'(mlpsig_pkg::STORE_DEPTH));
				st_wdata = wval_q;
			end
			mlpsig_pkg::OP_UIH, mlpsig_pkg::OP_UHO: begin
				st_we    = 1'b1;
				st_wdata = mlpsig_pkg::sat_add(w_rd, prod_rs);
			end
			mlpsig_pkg::OP_UBH: begin
				st_we    = 1'b1;
				st_wdata = mlpsig_pkg::sat_add(w_rd, dhid_sel);
			end
			mlpsig_pkg::OP_UBO: begin
				st_we    = 1'b1;
				st_wdata = mlpsig_pkg::sat_add(w_rd, dout_sel);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int n = 0; n < mlpsig_pkg::STORE_DEPTH; n++)
				store_q[n] <= '0;
		end else if (st_we) begin
			store_q[addr] <= st_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= req.mode;
			x_q[0] <= req.x_first;
			x_q[1] <= req.x_second;
			t_q[0] <= req.target_first;
			t_q[1] <= req.target_second;
			t_q[2] <= req.target_third;
			widx_q <= req.weight_index;
			wval_q <= req.weight_value;
			for (int k = 0; k < mlpsig_pkg::OUT_COUNT; k++)
				y_q[k] <= '0;
		end
		case (cmd.op)
			mlpsig_pkg::OP_HB, mlpsig_pkg::OP_OB:
				acc_q <= {{12{w_rd[15]}}, w_rd, 12'd0};
			mlpsig_pkg::OP_HX, mlpsig_pkg::OP_OH, mlpsig_pkg::OP_HE:
				acc_q <= acc_q + prod40;
			mlpsig_pkg::OP_HC:
				acc_q <= '0;
			mlpsig_pkg::OP_HS:
				h_q[cmd.sel_j] <= mlpsig_pkg::sigmoid(mlpsig_pkg::rnd_sat(acc_q));
			mlpsig_pkg::OP_OS:
				y_q[cmd.sel_k] <= mlpsig_pkg::sigmoid(mlpsig_pkg::rnd_sat(acc_q));
			mlpsig_pkg::OP_DY:
				tmp_q <= prod_rs;
			mlpsig_pkg::OP_DO:
				dout_q[cmd.sel_k] <= prod_rs;
			mlpsig_pkg::OP_DH1: begin
				tmp_q  <= prod_rs;
				tmp2_q <= mlpsig_pkg::rnd_sat(acc_q);
			end
			mlpsig_pkg::OP_DH2:
				dhid_q[cmd.sel_j] <= prod_rs;
			default: ;
		endcase
		if (cmd.finish) begin
			// load and unused-mode transactions leave y cleared
			rsp_q.y_first  <= (mode_q == mlpsig_pkg::MODE_LOAD) ? 13'd0 : y_q[0];
			rsp_q.y_second <= (mode_q == mlpsig_pkg::MODE_LOAD) ? 13'd0 : y_q[1];
			rsp_q.y_third  <= (mode_q == mlpsig_pkg::MODE_LOAD) ? 13'd0 : y_q[2];
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== src/mlp_sigmoid_train_and_infer.sv =====
// ----------------------------------------------------------------------------
// mlp_sigmoid_train_and_infer
// 2-4-3 sigmoid perceptron with on-line backpropagation training.
// ----------------------------------------------------------------------------
// One request transaction gives one response transaction. Mode 0 runs the
// forward pass and returns the three sigmoid outputs (Q0.12); mode 1 does the
// same and then applies one backpropagation step at rate 1, returning the
// outputs computed before the update; mode 2 writes one word of the weight
// store (indices past the store are ignored); mode 3 does nothing. Load and
// mode 3 responses are zero. Weights and biases are signed Q4.12, saturating,
// and all clear to zero at reset. Every product goes through a single shared
// multiplier stepped by the sequencer, one multiply-accumulate a cycle. One
// transaction is in flight at a time; a finished response sits in an output
// register, and the next request is taken while it waits to be collected.
// ----------------------------------------------------------------------------
module mlp_sigmoid_train_and_infer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  mlpsig_pkg::req_t   req,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output mlpsig_pkg::rsp_t   rsp
);

	// step command from sequencer to datapath
	mlpsig_pkg::cmd_t cmd;

	mlpsig_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.mode      (req.mode),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	mlpsig_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ===== test/mlp_checker.sv =====
// ----------------------------------------------------------------------------
// mlp_checker
// Watches both channels, predicts each response and compares it.
// ----------------------------------------------------------------------------
// Keeps its own weight store and sigmoid table, works out the outputs of every
// accepted request and checks responses in order against them.
// ----------------------------------------------------------------------------
module mlp_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  logic             req_ready,
	input  mlpsig_pkg::req_t req,
	input  logic             rsp_valid,
	input  logic             rsp_ready,
	input  mlpsig_pkg::rsp_t rsp,
	output int               errors,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	int               net_store [mlpsig_pkg::STORE_DEPTH];
	int               sig_lut [mlpsig_pkg::SIG_DEPTH];
	mlpsig_pkg::rsp_t outputs_due [$];

	function automatic int clamp16(longint v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return int'(v);
	endfunction

	// round half up from Q.24 back to Q4.12, saturating
	function automatic int fx_round(longint p);
		return clamp16((p + 2048) >>> 12);
	endfunction

	function automatic longint exp_neg(longint u);
		longint term;
		longint sum;
		term = 64'sd1 << 30;
		sum  = term;
		for (int k = 1; k <= 14; k++) begin
			term = term * u / (32768 * k);
			sum  = (k % 2) ? sum - term : sum + term;
		end
		if (sum < 0)
			sum = 0;
		for (int n = 0; n < 3; n++)
			sum = (sum * sum + (64'sd1 << 29)) >>> 30;
		return sum;
	endfunction

	function automatic int sigmoid_of(int v);
		return sig_lut[((v + 32768) * mlpsig_pkg::SIG_DEPTH) / 65536];
	endfunction

	function automatic int slope_of(int y);
		return fx_round(longint'(y) * longint'(4096 - y));
	endfunction

	function automatic mlpsig_pkg::rsp_t forward_and_learn(mlpsig_pkg::req_t r);
		int     x [mlpsig_pkg::IN_COUNT];
		int     t [mlpsig_pkg::OUT_COUNT];
		int     h [mlpsig_pkg::HIDDEN_COUNT];
		int     y [mlpsig_pkg::OUT_COUNT];
		int     dout [mlpsig_pkg::OUT_COUNT];
		int     dhid [mlpsig_pkg::HIDDEN_COUNT];
		int     p;
		longint acc;
		mlpsig_pkg::rsp_t o;
		o = '0;
		if (r.mode == mlpsig_pkg::MODE_LOAD) begin
			if (r.weight_index < mlpsig_pkg::STORE_DEPTH)
				net_store[r.weight_index] = int'(r.weight_value);
			return o;
		end
		if (r.mode != mlpsig_pkg::MODE_PREDICT && r.mode != mlpsig_pkg::MODE_TRAIN)
			return o;
		x[0] = int'(r.x_first);
		x[1] = int'(r.x_second);
		t[0] = int'(r.target_first);
		t[1] = int'(r.target_second);
		t[2] = int'(r.target_third);
		for (int j = 0; j < mlpsig_pkg::HIDDEN_COUNT; j++) begin
			acc = longint'(net_store[mlpsig_pkg::OFF_BH + j]) * 4096;
			for (int i = 0; i < mlpsig_pkg::IN_COUNT; i++)
				acc += longint'(x[i]) * net_store[i * mlpsig_pkg::HIDDEN_COUNT + j];
			h[j] = sigmoid_of(fx_round(acc));
		end
		for (int k = 0; k < mlpsig_pkg::OUT_COUNT; k++) begin
			acc = longint'(net_store[mlpsig_pkg::OFF_BO + k]) * 4096;
			for (int j = 0; j < mlpsig_pkg::HIDDEN_COUNT; j++)
				acc += longint'(h[j])
					* net_store[mlpsig_pkg::OFF_HO + j * mlpsig_pkg::OUT_COUNT + k];
			y[k] = sigmoid_of(fx_round(acc));
		end
		if (r.mode == mlpsig_pkg::MODE_TRAIN) begin
			for (int k = 0; k < mlpsig_pkg::OUT_COUNT; k++)
				dout[k] = fx_round(longint'(t[k] - y[k]) * slope_of(y[k]));
			// hidden error uses the weights before this step
			for (int j = 0; j < mlpsig_pkg::HIDDEN_COUNT; j++) begin
				acc = 0;
				for (int k = 0; k < mlpsig_pkg::OUT_COUNT; k++)
					acc += longint'(dout[k])
						* net_store[mlpsig_pkg::OFF_HO + j * mlpsig_pkg::OUT_COUNT + k];
				dhid[j] = fx_round(longint'(fx_round(acc)) * slope_of(h[j]));
			end
			for (int i = 0; i < mlpsig_pkg::IN_COUNT; i++)
				for (int j = 0; j < mlpsig_pkg::HIDDEN_COUNT; j++) begin
					p = i * mlpsig_pkg::HIDDEN_COUNT + j;
					net_store[p] = clamp16(longint'(net_store[p])
						+ fx_round(longint'(x[i]) * dhid[j]));
				end
			for (int j = 0; j < mlpsig_pkg::HIDDEN_COUNT; j++)
				for (int k = 0; k < mlpsig_pkg::OUT_COUNT; k++) begin
					p = mlpsig_pkg::OFF_HO + j * mlpsig_pkg::OUT_COUNT + k;
					net_store[p] = clamp16(longint'(net_store[p])
						+ fx_round(longint'(h[j]) * dout[k]));
				end
			for (int j = 0; j < mlpsig_pkg::HIDDEN_COUNT; j++)
				net_store[mlpsig_pkg::OFF_BH + j] =
					clamp16(longint'(net_store[mlpsig_pkg::OFF_BH + j]) + dhid[j]);
			for (int k = 0; k < mlpsig_pkg::OUT_COUNT; k++)
				net_store[mlpsig_pkg::OFF_BO + k] =
					clamp16(longint'(net_store[mlpsig_pkg::OFF_BO + k]) + dout[k]);
		end
		o.y_first  = 13'(y[0]);
		o.y_second = 13'(y[1]);
		o.y_third  = 13'(y[2]);
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [12:0] got, logic [12:0] want);
		$display("mismatch %s: got %0d, want %0d at %0t", field, got, want, $realtime);
		errors++;
	endtask

	initial begin
		longint c;
		longint m;
		longint ex;
		longint den;
		for (int e = 0; e < mlpsig_pkg::SIG_DEPTH; e++) begin
			c   = ((2 * e + 1) * 32768) / mlpsig_pkg::SIG_DEPTH - 32768;
			m   = (c < 0) ? -c : c;
			ex  = exp_neg(m);
			den = (64'sd1 << 30) + ex;
			if (c >= 0)
				sig_lut[e] = int'(((64'sd1 << 43) + den) / (2 * den));
			else
				sig_lut[e] = int'((ex * 8192 + den) / (2 * den));
		end
	end

	assign pending = outputs_due.size();

	always @(posedge clk or negedge arst_n) begin
		mlpsig_pkg::rsp_t want;
		if (!arst_n) begin
			errors = 0;
			foreach (net_store[i])
				net_store[i] = 0;
			outputs_due.delete();
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outputs_due.size() == 0) begin
					$display("response transaction with nothing outstanding at %0t", $realtime);
					errors++;
				end else begin
					want = outputs_due.pop_front();
					if (rsp.y_first !== want.y_first)
						report_mismatch("y_first", rsp.y_first, want.y_first);
					if (rsp.y_second !== want.y_second)
						report_mismatch("y_second", rsp.y_second, want.y_second);
					if (rsp.y_third !== want.y_third)
						report_mismatch("y_third", rsp.y_third, want.y_third);
				end
			end
			if (req_valid && req_ready)
				outputs_due = {outputs_due, forward_and_learn(req)};
		end
	end

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the sigmoid perceptron.
// ----------------------------------------------------------------------------
// Directed corner requests, then random weight loads, training, predict and mode 3
// transactions with random gaps and stalls on both channels. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 5000;  // cycles with no transaction at all
	localparam int REQ_W      = $bits(mlpsig_pkg::req_t);

	logic             clk;
	logic             arst_n;
	logic             req_valid;
	logic             req_ready;
	mlpsig_pkg::req_t req;
	logic             rsp_valid;
	logic             rsp_ready;
	mlpsig_pkg::rsp_t rsp;
	int               errors;
	int               pending;

	bit   busy_run;    // no gaps on either side while set, unless a long hold-off runs
	bit   long_hold;   // receiver holds off for a long stretch
	int   quiet_cycles;

	mlp_sigmoid_train_and_infer dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
	);

	mlp_checker chk (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_ready(req_ready), .req(req),
		.rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp),
		.errors(errors), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic int gap_len();
		if (busy_run)
			return 0;
		// mostly short, now and then long
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(10, 60);
	endfunction

	// Offer one transaction and hold it until taken; called at a rising edge
	task automatic offer(mlpsig_pkg::req_t r);
		int g;
		req       <= r;
		req_valid <= 1'b1;
		do
			@(posedge clk);
		while (!req_ready);
		g = gap_len();
		if (g > 0) begin
			req_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	function automatic mlpsig_pkg::req_t blank_req(logic [1:0] m);
		mlpsig_pkg::req_t r;
		r      = '0;
		r.mode = m;
		return r;
	endfunction

	function automatic logic [15:0] rand_q412();
		// mostly moderate values, sometimes the full range
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom());
		return 16'($urandom_range(0, 16383) - 8192);
	endfunction

	function automatic logic [12:0] rand_target();
		if ($urandom_range(0, 19) == 0)
			return 13'($urandom());
		return 13'($urandom_range(0, 4096));
	endfunction

	task automatic load_word(int idx, logic [15:0] v);
		mlpsig_pkg::req_t r;
		r              = blank_req(mlpsig_pkg::MODE_LOAD);
		r.weight_index = 5'(idx);
		r.weight_value = v;
		offer(r);
	endtask

	task automatic run_sample(logic [1:0] m, logic [15:0] xa, logic [15:0] xb,
		logic [12:0] ta, logic [12:0] tb2, logic [12:0] tc);
		mlpsig_pkg::req_t r;
		r               = blank_req(m);
		r.x_first       = xa;
		r.x_second      = xb;
		r.target_first  = ta;
		r.target_second = tb2;
		r.target_third  = tc;
		offer(r);
	endtask

	task automatic random_sample();
		mlpsig_pkg::req_t r;
		int               pick;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			// load, now and then past the end of the store
			r              = blank_req(mlpsig_pkg::MODE_LOAD);
			r.weight_index = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(27, 31))
				: 5'($urandom_range(0, mlpsig_pkg::STORE_DEPTH - 1));
			r.weight_value = rand_q412();
			offer(r);
		end else if (pick < 12) begin
			r = REQ_W'({$urandom(), $urandom(), $urandom()});
			r.mode = mlpsig_pkg::MODE_SPARE;
			offer(r);
		end else begin
			run_sample((pick < 56) ? mlpsig_pkg::MODE_TRAIN : mlpsig_pkg::MODE_PREDICT,
				rand_q412(), rand_q412(), rand_target(), rand_target(), rand_target());
		end
	endtask

	// Receiver: random ready, with a long hold-off when asked
	initial begin
		int hold;
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold) begin
				rsp_ready <= 1'b0;
				for (hold = 0; hold < 400; hold++)
					@(posedge clk);
				long_hold = 1'b0;
			end else if (busy_run) begin
				rsp_ready <= 1'b1;
			end else if ($urandom_range(0, 49) == 0) begin
				rsp_ready <= 1'b0;
				repeat ($urandom_range(10, 60)) @(posedge clk);
			end else begin
				rsp_ready <= ($urandom_range(0, 9) < 7);
			end
		end
	end

	// Watchdog on cycles without any transaction
	initial begin
		quiet_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		busy_run  = 1'b0;
		long_hold = 1'b0;
		arst_n    <= 1'b0;
		req_valid <= 1'b0;
		req       <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: cleared store first, then extremes of every field
		run_sample(mlpsig_pkg::MODE_PREDICT, 16'h7fff, 16'h8000, 13'd0, 13'd4096, 13'd0);
		run_sample(mlpsig_pkg::MODE_TRAIN, 16'h8000, 16'h7fff, 13'd4096, 13'd0, 13'd8191);
		run_sample(mlpsig_pkg::MODE_TRAIN, 16'h0000, 16'h0000, 13'd0, 13'd0, 13'd0);
		load_word(mlpsig_pkg::STORE_DEPTH - 1, 16'h7fff);
		load_word(0, 16'h8000);
		load_word(mlpsig_pkg::OFF_HO, 16'h7fff);
		load_word(mlpsig_pkg::OFF_BH, 16'h8000);
		load_word(mlpsig_pkg::STORE_DEPTH, 16'h1234);  // past the end: ignored
		load_word(31, 16'hffff);
		run_sample(mlpsig_pkg::MODE_PREDICT, 16'h7fff, 16'h7fff, 13'd4096, 13'd4096,
			13'd4096);
		run_sample(mlpsig_pkg::MODE_TRAIN, 16'h8000, 16'h8000, 13'd8191, 13'd8191,
			13'd8191);
		run_sample(mlpsig_pkg::MODE_TRAIN, 16'h1000, 16'hf000, 13'd0, 13'd4096, 13'd2048);
		offer(mlpsig_pkg::req_t'('1));      // mode three, every bit set
		run_sample(mlpsig_pkg::MODE_PREDICT, 16'h0001, 16'hffff, 13'd1, 13'd1, 13'd1);

		// Random: fresh weights, then a stream of mixed transactions
		for (int n = 0; n < 560; n++) begin
			if (n % 150 == 0)
				for (int w = 0; w < mlpsig_pkg::STORE_DEPTH; w++)
					load_word(w, rand_q412());
			if (n % 90 == 40)
				busy_run = ~busy_run;
			if (n == 300)
				long_hold = 1'b1;
			if (n == 500) begin
				req_valid <= 1'b0;
				wait (pending == 0);
				@(posedge clk);
			end
			random_sample();
		end
		busy_run = 1'b0;
		req_valid <= 1'b0;

		wait (pending == 0);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
